>>> sv/gbn_pkg.sv
// Shared types and constants for the Go-Back-N sequence control block.
// Used by the front queue, the back executor and the top level.
// Depends on nothing.
package gbn_pkg;

   // Sequence number and window sizing.
   localparam int SEQ_BITS    = 16;
   localparam int SEND_DEPTH  = 16;
   localparam int RECV_WINDOW = 16;
   localparam int OFF_BITS    = (RECV_WINDOW > 1) ? $clog2(RECV_WINDOW) : 1;
   localparam int ADV_BITS    = $clog2(RECV_WINDOW + 1);
   localparam logic [SEQ_BITS-1:0] SEQ_MAX = '1;

   // Configuration register widths and reset values.
   localparam int WIN_BITS = 5;
   localparam int AGE_BITS = 8;
   localparam logic [WIN_BITS-1:0] WINDOW_RESET   = 5'd4;
   localparam logic [AGE_BITS-1:0] ACK_TO_RESET   = 8'd1;
   localparam logic [AGE_BITS-1:0] DEAD_TO_RESET  = 8'd5;
   localparam logic [AGE_BITS-1:0] AGE_MAX        = '1;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // Configuration port.
   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [1:0] REG_WINDOW  = 2'd0;
   localparam logic [1:0] REG_ACK_TO  = 2'd1;
   localparam logic [1:0] REG_DEAD_TO = 2'd2;

   typedef logic [SEQ_BITS-1:0] seq_type;
   typedef logic [RECV_WINDOW-1:0] map_type;

   // Request codes.
   typedef enum logic [2:0] {
      OP_SUBMIT  = 3'd0,
      OP_ACK     = 3'd1,
      OP_DATA    = 3'd2,
      OP_SEND    = 3'd3,
      OP_DELIVER = 3'd4,
      OP_TICK    = 3'd5,
      OP_CLOSE   = 3'd6,
      OP_UNKNOWN = 3'd7
   } op_type;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_NONE = 2'd1,
      ST_FULL = 2'd2,
      ST_DROP = 2'd3
   } status_type;

   // Executor states.
   typedef enum logic [1:0] {
      BK_IDLE    = 2'd0,
      BK_EXEC    = 2'd1,
      BK_ADVANCE = 2'd2
   } back_state_type;

   // One classified command.
   typedef struct packed {
      op_type  op;
      seq_type seqno;
   } cmd_type;

   // Head of the command queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } qhead_type;

   // Timeout settings.
   typedef struct packed {
      logic [AGE_BITS-1:0] ack_timeout;
      logic [AGE_BITS-1:0] dead_timeout;
   } cfg_type;

   // Window size write, which also moves the top of the window.
   typedef struct packed {
      logic                write;
      logic [WIN_BITS-1:0] value;
   } win_wr_type;

   // One result transaction.
   typedef struct packed {
      status_type status;
      seq_type    out_seqno;
      seq_type    out_base;
      seq_type    out_top;
      seq_type    out_next_send;
      seq_type    out_expected;
      logic       link_dead;
      logic       send_done;
   } result_type;

endpackage

>>> sv/gbn_front.sv
// Front end: accepts request transactions, decodes the request code and
// holds them in a two-entry queue for the executor.
// Depends on gbn_pkg.
module gbn_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_type,
   input  logic [15:0]       req_seqno,
   input  logic              q_pop,
   output gbn_pkg::qhead_type q_head
);
   import gbn_pkg::*;

   cmd_type               mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  push;
   logic                  pop;
   cmd_type               cmd_dec;

   // Decode the request code.
   always_comb begin
      cmd_dec.seqno = req_seqno;
      unique case (op_type'(req_type))
         OP_SUBMIT:  cmd_dec.op = OP_SUBMIT;
         OP_ACK:     cmd_dec.op = OP_ACK;
         OP_DATA:    cmd_dec.op = OP_DATA;
         OP_SEND:    cmd_dec.op = OP_SEND;
         OP_DELIVER: cmd_dec.op = OP_DELIVER;
         OP_TICK:    cmd_dec.op = OP_TICK;
         OP_CLOSE:   cmd_dec.op = OP_CLOSE;
         default:    cmd_dec.op = OP_UNKNOWN;
      endcase
   end

   // Queue handshake.
   assign req_stall    = (count_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign push         = req_valid && !req_stall;
   assign pop          = q_pop && (count_ff != '0);
   assign q_head.valid = (count_ff != '0);
   assign q_head.cmd   = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= cmd_dec;
      end
   end

endmodule

>>> sv/gbn_back.sv
// Back end: executes queued commands against the sender and receiver
// sequence state and holds the result transaction in an output register.
// Depends on gbn_pkg.
module gbn_back (
   input  logic                clock,
   input  logic                reset,
   input  gbn_pkg::qhead_type  q_head,
   output logic                q_pop,
   input  gbn_pkg::cfg_type    cfg,
   input  gbn_pkg::win_wr_type win_wr,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output gbn_pkg::result_type rsp_data
);
   import gbn_pkg::*;

   // Top of a window that starts at b; a size of zero counts as one.
   function automatic seq_type top_from(input seq_type b, input logic [WIN_BITS-1:0] ws);
      logic [WIN_BITS-1:0] span;
      logic [SEQ_BITS:0]   sum;
      span = (ws == '0) ? WIN_BITS'(1) : ws;
      sum  = {1'b0, b} + (SEQ_BITS + 1)'(span) - 1'b1;
      return sum[SEQ_BITS] ? SEQ_MAX : sum[SEQ_BITS-1:0];
   endfunction

   back_state_type      state_ff, state_in;
   cmd_type             cur_ff, cur_in;
   seq_type             base_ff, base_in;
   seq_type             top_ff, top_in;
   seq_type             add_ff, add_in;
   seq_type             send_ff, send_in;
   seq_type             expect_ff, expect_in;
   seq_type             deliver_ff, deliver_in;
   map_type             map_ff, map_in;
   logic [AGE_BITS-1:0] ack_age_ff, ack_age_in;
   logic [AGE_BITS-1:0] stall_age_ff, stall_age_in;
   logic                stall_ff, stall_in;
   logic                closed_ff, closed_in;
   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_ff, rsp_in;

   logic                out_free;
   logic                fin;
   status_type          status_c;
   seq_type             oseq_c;
   logic                submit_full;
   seq_type             ack_sn;
   logic [SEQ_BITS:0]   top_sum;
   seq_type             data_off;
   logic                data_old;
   logic                data_drop;
   logic                data_set;
   logic [ADV_BITS-1:0] adv_cnt;
   logic [AGE_BITS-1:0] age_inc;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Request checks that do not depend on the state machine.
   assign submit_full = closed_ff || (add_ff >= SEQ_MAX) ||
                        ((add_ff - base_ff) >= SEQ_BITS'(SEND_DEPTH));
   assign ack_sn      = (cur_ff.seqno > add_ff) ? add_ff : cur_ff.seqno;
   assign top_sum     = {1'b0, top_ff} + {1'b0, ack_sn - base_ff};
   assign data_off    = cur_ff.seqno - expect_ff;
   assign data_old    = cur_ff.seqno < expect_ff;
   assign data_drop   = !data_old && ((cur_ff.seqno == SEQ_MAX) ||
                        (data_off >= SEQ_BITS'(RECV_WINDOW)));
   assign data_set    = (cur_ff.op == OP_DATA) && !data_old && !data_drop;
   assign age_inc     = (ack_age_ff == AGE_MAX) ? AGE_MAX : ack_age_ff + 1'b1;

   // Length of the run of arrived numbers at the bottom of the bitmap.
   always_comb begin
      adv_cnt = ADV_BITS'(RECV_WINDOW);
      for (int i = RECV_WINDOW - 1; i >= 0; i--) begin
         if (!map_ff[i]) begin
            adv_cnt = ADV_BITS'(i);
         end
      end
   end

   // Next state and command execution.
   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      base_in      = base_ff;
      top_in       = top_ff;
      add_in       = add_ff;
      send_in      = send_ff;
      expect_in    = expect_ff;
      deliver_in   = deliver_ff;
      map_in       = map_ff;
      ack_age_in   = ack_age_ff;
      stall_age_in = stall_age_ff;
      stall_in     = stall_ff;
      closed_in    = closed_ff;
      q_pop        = 1'b0;
      fin          = 1'b0;
      status_c     = ST_OK;
      oseq_c       = '0;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_head.valid) begin
               q_pop    = 1'b1;
               cur_in   = q_head.cmd;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            if (data_set) begin
               // Mark the arrival; the advance over arrived numbers follows in BK_ADVANCE.
               map_in       = map_ff | (map_type'(1) << data_off[OFF_BITS-1:0]);
               stall_in     = 1'b0;
               stall_age_in = '0;
               state_in     = BK_ADVANCE;
            end else if (out_free) begin
               fin = 1'b1;
               case (cur_ff.op)
                  OP_SUBMIT: begin
                     if (submit_full) begin
                        status_c = ST_FULL;
                     end else begin
                        if (add_ff == '0) begin
                           ack_age_in = '0;
                        end
                        oseq_c = add_ff;
                        add_in = add_ff + 1'b1;
                     end
                  end
                  OP_ACK: begin
                     if (ack_sn > base_ff) begin
                        top_in  = top_sum[SEQ_BITS] ? SEQ_MAX : top_sum[SEQ_BITS-1:0];
                        base_in = ack_sn;
                     end
                     ack_age_in   = '0;
                     stall_in     = 1'b0;
                     stall_age_in = '0;
                     oseq_c       = base_in;
                  end
                  OP_DATA: begin
                     // Old data or data beyond the bitmap.
                     if (data_drop) begin
                        status_c = ST_DROP;
                     end
                     stall_in     = 1'b0;
                     stall_age_in = '0;
                     oseq_c       = expect_ff;
                  end
                  OP_SEND: begin
                     if ((send_ff < add_ff) && (send_ff >= base_ff) && (send_ff <= top_ff)) begin
                        oseq_c  = send_ff;
                        send_in = send_ff + 1'b1;
                     end else begin
                        status_c = ST_NONE;
                     end
                  end
                  OP_DELIVER: begin
                     if (deliver_ff < expect_ff) begin
                        oseq_c     = deliver_ff;
                        deliver_in = deliver_ff + 1'b1;
                     end else begin
                        status_c = ST_NONE;
                     end
                  end
                  OP_TICK: begin
                     ack_age_in = age_inc;
                     if (stall_ff && (stall_age_ff != AGE_MAX)) begin
                        stall_age_in = stall_age_ff + 1'b1;
                     end
                     if (age_inc > cfg.ack_timeout) begin
                        // Timeout: go back to the base and start a stall.
                        send_in    = base_ff;
                        ack_age_in = '0;
                        if (!stall_ff) begin
                           stall_in     = 1'b1;
                           stall_age_in = '0;
                        end
                     end
                  end
                  OP_CLOSE: begin
                     closed_in = 1'b1;
                  end
                  default: begin
                     status_c = ST_NONE;
                  end
               endcase
            end
         end
         BK_ADVANCE: begin
            if (out_free) begin
               fin       = 1'b1;
               map_in    = map_ff >> adv_cnt;
               expect_in = expect_ff + SEQ_BITS'(adv_cnt);
               oseq_c    = expect_in;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      // Take the next command straight away when one is done.
      if (fin) begin
         if (q_head.valid) begin
            q_pop    = 1'b1;
            cur_in   = q_head.cmd;
            state_in = BK_EXEC;
         end else begin
            state_in = BK_IDLE;
         end
      end

      // A window size write moves the top of the window.
      if (win_wr.write) begin
         top_in = top_from(base_ff, win_wr.value);
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (fin) begin
         rsp_valid_in         = 1'b1;
         rsp_in.status        = status_c;
         rsp_in.out_seqno     = oseq_c;
         rsp_in.out_base      = base_in;
         rsp_in.out_top       = top_in;
         rsp_in.out_next_send = send_in;
         rsp_in.out_expected  = expect_in;
         rsp_in.link_dead     = stall_in && (stall_age_in >= cfg.dead_timeout);
         rsp_in.send_done     = closed_in && (base_in == add_in) && (send_in == add_in);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         base_ff      <= '0;
         top_ff       <= top_from('0, WINDOW_RESET);
         add_ff       <= '0;
         send_ff      <= '0;
         expect_ff    <= '0;
         deliver_ff   <= '0;
         map_ff       <= '0;
         ack_age_ff   <= '0;
         stall_age_ff <= '0;
         stall_ff     <= 1'b0;
         closed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         top_ff       <= top_in;
         add_ff       <= add_in;
         send_ff      <= send_in;
         expect_ff    <= expect_in;
         deliver_ff   <= deliver_in;
         map_ff       <= map_in;
         ack_age_ff   <= ack_age_in;
         stall_age_ff <= stall_age_in;
         stall_ff     <= stall_in;
         closed_ff    <= closed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> sv/go_back_n_sequence_control_top.sv
// Go-Back-N sequence control for one connection.
//
// Request channel (req_*): one transaction carries a request code and a
// sequence number: submit, ACK in, data in, send poll, deliver poll, tick,
// close. Every request gives exactly one result transaction on the rsp_*
// channel with a status, the number concerned and the window state after
// the request. Both channels use valid and stall.
// Requests enter a two-entry queue; the executor takes one command at a
// time. A request passes the queue and the current-command register before
// its result is registered (data in that lands in the receive bitmap also
// passes the advance state, which moves over arrived numbers). With a full
// queue and no stalled result the executor finishes one command per cycle,
// apart from such data in. A stalled result holds in the output register;
// the executor then waits and the queue fills, after which req_stall rises.
// Reset clears the queue, the sequence state and the registers to their
// defaults (window 4, ACK timeout 1, dead timeout 5).
// Registers sit on the csr_* port at byte addresses 0, 4 and 8; write them
// only while the block is idle.
// Depends on gbn_pkg, gbn_front and gbn_back.
module go_back_n_sequence_control_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_type,
   input  logic [15:0]                        req_seqno,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [15:0]                        rsp_out_seqno,
   output logic [15:0]                        rsp_out_base,
   output logic [15:0]                        rsp_out_top,
   output logic [15:0]                        rsp_out_next_send,
   output logic [15:0]                        rsp_out_expected,
   output logic                               rsp_link_dead,
   output logic                               rsp_send_done,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [gbn_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [gbn_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [gbn_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import gbn_pkg::*;

   logic [WIN_BITS-1:0] window_ff, window_in;
   logic [AGE_BITS-1:0] ack_to_ff, ack_to_in;
   logic [AGE_BITS-1:0] dead_to_ff, dead_to_in;
   logic                csr_write;
   logic [1:0]          csr_index;
   qhead_type           q_head;
   logic                q_pop;
   cfg_type             cfg;
   win_wr_type          win_wr;
   result_type          rsp_data;

   // Register file.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];

   always_comb begin
      window_in  = window_ff;
      ack_to_in  = ack_to_ff;
      dead_to_in = dead_to_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_WINDOW:  window_in  = csr_pwdata[WIN_BITS-1:0];
            REG_ACK_TO:  ack_to_in  = csr_pwdata[AGE_BITS-1:0];
            REG_DEAD_TO: dead_to_in = csr_pwdata[AGE_BITS-1:0];
            default:     ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_WINDOW:  csr_prdata = CSR_DATA_BITS'(window_ff);
         REG_ACK_TO:  csr_prdata = CSR_DATA_BITS'(ack_to_ff);
         REG_DEAD_TO: csr_prdata = CSR_DATA_BITS'(dead_to_ff);
         default:     csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff  <= WINDOW_RESET;
         ack_to_ff  <= ACK_TO_RESET;
         dead_to_ff <= DEAD_TO_RESET;
      end else begin
         window_ff  <= window_in;
         ack_to_ff  <= ack_to_in;
         dead_to_ff <= dead_to_in;
      end
   end

   assign cfg.ack_timeout  = ack_to_ff;
   assign cfg.dead_timeout = dead_to_ff;
   assign win_wr.write     = csr_write && (csr_index == REG_WINDOW);
   assign win_wr.value     = window_in;

   gbn_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_type  (req_type),
      .req_seqno (req_seqno),
      .q_pop     (q_pop),
      .q_head    (q_head)
   );

   gbn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .cfg       (cfg),
      .win_wr    (win_wr),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign rsp_status        = rsp_data.status;
   assign rsp_out_seqno     = rsp_data.out_seqno;
   assign rsp_out_base      = rsp_data.out_base;
   assign rsp_out_top       = rsp_data.out_top;
   assign rsp_out_next_send = rsp_data.out_next_send;
   assign rsp_out_expected  = rsp_data.out_expected;
   assign rsp_link_dead     = rsp_data.link_dead;
   assign rsp_send_done     = rsp_data.send_done;

   // No result is offered right after reset.
   a_reset_quiet: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // The window top never falls below its base.
   a_window_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_base <= rsp_out_top))
      else $error("window top below base");

   // A finished sender has its send pointer at the base.
   a_done_aligned: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_send_done) |-> (rsp_out_base == rsp_out_next_send))
      else $error("send done with send pointer away from base");

   // Dropped data still answers with the expected number.
   a_drop_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_DROP)) |-> (rsp_out_seqno == rsp_out_expected))
      else $error("dropped data answered with a wrong ACK number");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for go_back_n_sequence_control_top: directed rows, then random
// request streams under varying idle patterns, each result compared against a predictor.
// Depends on gbn_pkg and the go_back_n_sequence_control_top RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import gbn_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 8;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   logic [2:0]               req_type;
   logic [15:0]              req_seqno;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_status;
   logic [15:0]              rsp_out_seqno;
   logic [15:0]              rsp_out_base;
   logic [15:0]              rsp_out_top;
   logic [15:0]              rsp_out_next_send;
   logic [15:0]              rsp_out_expected;
   logic                     rsp_link_dead;
   logic                     rsp_send_done;
   logic                     csr_psel;
   logic                     csr_penable;
   logic                     csr_pwrite;
   logic [CSR_ADDR_BITS-1:0] csr_paddr;
   logic [CSR_DATA_BITS-1:0] csr_pwdata;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   go_back_n_sequence_control_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_seqno         (req_seqno),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_out_seqno     (rsp_out_seqno),
      .rsp_out_base      (rsp_out_base),
      .rsp_out_top       (rsp_out_top),
      .rsp_out_next_send (rsp_out_next_send),
      .rsp_out_expected  (rsp_out_expected),
      .rsp_link_dead     (rsp_link_dead),
      .rsp_send_done     (rsp_send_done),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   // Predicted connection state and register copies.
   logic [WIN_BITS-1:0] cfg_window;
   logic [AGE_BITS-1:0] cfg_ack_limit;
   logic [AGE_BITS-1:0] cfg_dead_limit;
   seq_type             snd_base;
   seq_type             snd_top;
   seq_type             snd_added;
   seq_type             snd_next;
   seq_type             rcv_expect;
   seq_type             rcv_deliver;
   map_type             rcv_early_map;
   logic [AGE_BITS-1:0] ack_ticks;
   logic [AGE_BITS-1:0] stall_ticks;
   logic                stall_on;
   logic                is_closed;

   // Results owed by the block, oldest first.
   result_type due_reports[$];
   int         bad_fields = 0;
   int         quiet_cycles = 0;
   int         send_idle_pct = 13;
   int         recv_stall_pct = 66;

   // One directed request, with a hand-written result where it is obvious.
   typedef struct {
      op_type     op;
      seq_type    sn;
      bit         typed;
      result_type want;
   } step_row_type;

   // Opening rows run from the reset state (window 4, so top is 3).
   step_row_type opening_rows [25] = '{
      '{OP_SEND,    16'd0,     1'b1, '{ST_NONE, 16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{OP_DELIVER, 16'd0,     1'b1, '{ST_NONE, 16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{OP_UNKNOWN, 16'hFFFF,  1'b1, '{ST_NONE, 16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{OP_DATA,    16'hFFFF,  1'b1, '{ST_DROP, 16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{OP_DATA,    16'd16,    1'b1, '{ST_DROP, 16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{OP_ACK,     16'hFFFF,  1'b1, '{ST_OK,   16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{OP_TICK,    16'd0,     1'b1, '{ST_OK,   16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{OP_SUBMIT,  16'd0,     1'b1, '{ST_OK,   16'd0, 16'd0, 16'd3, 16'd0, 16'd0, 1'b0, 1'b0}},
      '{OP_SUBMIT,  16'd0,     1'b0, '0},
      '{OP_SUBMIT,  16'hFFFF,  1'b0, '0},
      '{OP_SEND,    16'd0,     1'b0, '0},
      '{OP_SEND,    16'd0,     1'b0, '0},
      '{OP_TICK,    16'd0,     1'b0, '0},
      '{OP_TICK,    16'd0,     1'b0, '0},
      '{OP_ACK,     16'd1,     1'b0, '0},
      '{OP_ACK,     16'd0,     1'b0, '0},
      '{OP_ACK,     16'hFFFF,  1'b0, '0},
      '{OP_DATA,    16'd1,     1'b0, '0},
      '{OP_DATA,    16'd15,    1'b0, '0},
      '{OP_DATA,    16'd0,     1'b0, '0},
      '{OP_DATA,    16'd0,     1'b0, '0},
      '{OP_DELIVER, 16'd0,     1'b0, '0},
      '{OP_DELIVER, 16'd0,     1'b0, '0},
      '{OP_DATA,    16'd17,    1'b0, '0},
      '{OP_DATA,    16'd18,    1'b0, '0}
   };

   // Closing rows: close, then drain the sender so that send_done rises.
   step_row_type closing_rows [8] = '{
      '{OP_CLOSE,   16'd0,     1'b0, '0},
      '{OP_SUBMIT,  16'd0,     1'b0, '0},
      '{OP_ACK,     16'hFFFF,  1'b0, '0},
      '{OP_TICK,    16'd0,     1'b0, '0},
      '{OP_TICK,    16'd0,     1'b0, '0},
      '{OP_SEND,    16'd0,     1'b0, '0},
      '{OP_DATA,    16'd0,     1'b0, '0},
      '{OP_DELIVER, 16'd0,     1'b0, '0}
   };

   // Top of the window for a given base, saturated at the largest number.
   function automatic seq_type window_top(seq_type b);
      logic [SEQ_BITS:0] t;
      t = {1'b0, b} + (SEQ_BITS + 1)'((cfg_window == '0) ? 1 : cfg_window) - 1'b1;
      return (t > SEQ_MAX) ? SEQ_MAX : t[SEQ_BITS-1:0];
   endfunction

   function automatic void reset_connection();
      cfg_window     = WINDOW_RESET;
      cfg_ack_limit  = ACK_TO_RESET;
      cfg_dead_limit = DEAD_TO_RESET;
      snd_base       = '0;
      snd_top        = window_top('0);
      snd_added      = '0;
      snd_next       = '0;
      rcv_expect     = '0;
      rcv_deliver    = '0;
      rcv_early_map  = '0;
      ack_ticks      = '0;
      stall_ticks    = '0;
      stall_on       = 1'b0;
      is_closed      = 1'b0;
   endfunction

   // Register write as seen by the connection state; returns the stored value.
   function automatic logic [CSR_DATA_BITS-1:0] apply_register(logic [1:0] idx,
                                                               logic [CSR_DATA_BITS-1:0] value);
      case (idx)
         REG_WINDOW: begin
            cfg_window = value[WIN_BITS-1:0];
            snd_top    = window_top(snd_base);
            return CSR_DATA_BITS'(cfg_window);
         end
         REG_ACK_TO: begin
            cfg_ack_limit = value[AGE_BITS-1:0];
            return CSR_DATA_BITS'(cfg_ack_limit);
         end
         default: begin
            cfg_dead_limit = value[AGE_BITS-1:0];
            return CSR_DATA_BITS'(cfg_dead_limit);
         end
      endcase
   endfunction

   // Apply one request to the connection and return the result it produces.
   function automatic result_type step_connection(op_type op, seq_type sn);
      result_type        r;
      seq_type           acked;
      seq_type           off;
      logic [SEQ_BITS:0] t;
      r        = '0;
      r.status = ST_OK;
      case (op)
         OP_SUBMIT: begin
            if (is_closed || snd_added == SEQ_MAX || (snd_added - snd_base) >= SEND_DEPTH) begin
               r.status = ST_FULL;
            end else begin
               if (snd_added == 0) ack_ticks = '0;
               r.out_seqno = snd_added;
               snd_added++;
            end
         end
         OP_ACK: begin
            // An ACK beyond what was submitted counts as acknowledging everything.
            acked = (sn > snd_added) ? snd_added : sn;
            if (acked > snd_base) begin
               t        = snd_top + (acked - snd_base);
               snd_top  = (t > SEQ_MAX) ? SEQ_MAX : t[SEQ_BITS-1:0];
               snd_base = acked;
            end
            ack_ticks   = '0;
            stall_on    = 1'b0;
            stall_ticks = '0;
            r.out_seqno = snd_base;
         end
         OP_DATA: begin
            // Old data is only acknowledged; data past the bitmap is dropped.
            if (sn >= rcv_expect) begin
               off = sn - rcv_expect;
               if (sn == SEQ_MAX || off >= RECV_WINDOW) begin
                  r.status = ST_DROP;
               end else begin
                  rcv_early_map[off[OFF_BITS-1:0]] = 1'b1;
                  while (rcv_early_map[0]) begin
                     rcv_early_map = rcv_early_map >> 1;
                     rcv_expect++;
                  end
               end
            end
            stall_on    = 1'b0;
            stall_ticks = '0;
            r.out_seqno = rcv_expect;
         end
         OP_SEND: begin
            if (snd_next < snd_added && snd_next >= snd_base && snd_next <= snd_top) begin
               r.out_seqno = snd_next;
               snd_next++;
            end else begin
               r.status = ST_NONE;
            end
         end
         OP_DELIVER: begin
            if (rcv_deliver < rcv_expect) begin
               r.out_seqno = rcv_deliver;
               rcv_deliver++;
            end else begin
               r.status = ST_NONE;
            end
         end
         OP_TICK: begin
            if (ack_ticks != AGE_MAX) ack_ticks++;
            if (stall_on && stall_ticks != AGE_MAX) stall_ticks++;
            // Timeout: go back to the base and start a stall if none is running.
            if (ack_ticks > cfg_ack_limit) begin
               snd_next  = snd_base;
               ack_ticks = '0;
               if (!stall_on) begin
                  stall_on    = 1'b1;
                  stall_ticks = '0;
               end
            end
         end
         OP_CLOSE: begin
            is_closed = 1'b1;
         end
         default: begin
            r.status = ST_NONE;
         end
      endcase
      r.out_base      = snd_base;
      r.out_top       = snd_top;
      r.out_next_send = snd_next;
      r.out_expected  = rcv_expect;
      r.link_dead     = stall_on && (stall_ticks >= cfg_dead_limit);
      r.send_done     = is_closed && snd_base == snd_added && snd_next == snd_added;
      return r;
   endfunction

   function automatic void check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         bad_fields++;
         if (bad_fields <= 10) begin
            $display("Mismatch in %s: expected %0d, got %0d", field, want, got);
         end
      end
   endfunction

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The result side stalls at random.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
   end

   // Compare each result transaction with the oldest prediction.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (due_reports.size() == 0) begin
            bad_fields++;
            if (bad_fields <= 10) $display("Result transaction with no request outstanding");
         end else begin
            want = due_reports.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("out_seqno", want.out_seqno, rsp_out_seqno);
            check_field("out_base", want.out_base, rsp_out_base);
            check_field("out_top", want.out_top, rsp_out_top);
            check_field("out_next_send", want.out_next_send, rsp_out_next_send);
            check_field("out_expected", want.out_expected, rsp_out_expected);
            check_field("link_dead", want.link_dead, rsp_link_dead);
            check_field("send_done", want.send_done, rsp_send_done);
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Present one request, wait for its acceptance and record the predicted result.
   task automatic send_request(op_type op, seq_type sn);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_type  <= op;
      req_seqno <= sn;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      due_reports.push_back(step_connection(op, sn));
   endtask

   // Wait until every owed result has arrived, then let the pipeline settle.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (due_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write a register, then read it back.
   task automatic csr_write(logic [1:0] idx, logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] stored;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'({idx, 2'b00});
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      stored = apply_register(idx, value);
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      check_field("register readback", stored, csr_prdata);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_settings(int win, int ack_limit, int dead_limit);
      csr_write(REG_WINDOW, CSR_DATA_BITS'(win));
      csr_write(REG_ACK_TO, CSR_DATA_BITS'(ack_limit));
      csr_write(REG_DEAD_TO, CSR_DATA_BITS'(dead_limit));
   endtask

   // One short burst of traffic; most bursts are well-formed sender or receiver flows.
   task automatic random_burst();
      int pick;
      int n;
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
         n = $urandom_range(1, 6);
         repeat (n) send_request(OP_SUBMIT, seq_type'($urandom));
         repeat (n + $urandom_range(0, 2)) send_request(OP_SEND, seq_type'($urandom));
         if ($urandom_range(0, 9) < 7) begin
            send_request(OP_ACK, seq_type'(int'(snd_base) +
                                           $urandom_range(0, int'(snd_added - snd_base) + 2)));
         end
      end else if (pick < 60) begin
         n = $urandom_range(1, 6);
         repeat (n) send_request(OP_DATA, seq_type'(int'(rcv_expect) + $urandom_range(0, 20) - 2));
         repeat ($urandom_range(0, 3)) send_request(OP_DELIVER, seq_type'($urandom));
      end else if (pick < 72) begin
         repeat ($urandom_range(1, 4)) send_request(OP_TICK, seq_type'($urandom));
      end else if (pick < 82) begin
         repeat ($urandom_range(1, 3)) begin
            send_request(op_type'($urandom_range(0, 7)), seq_type'($urandom));
         end
      end else if (pick < 90) begin
         send_request(OP_ACK, seq_type'($urandom));
         send_request(OP_DATA, seq_type'($urandom));
      end else begin
         send_request(OP_SEND, seq_type'($urandom));
         send_request(OP_DELIVER, seq_type'($urandom));
      end
   endtask

   // Random traffic; with with_storm, a long tick run midway can saturate the age counters.
   task automatic random_phase(int target, bit with_storm);
      bit storm_done;
      storm_done = !with_storm;
      for (int issued = 0; issued < target; issued += 4) begin
         random_burst();
         if (!storm_done && issued >= target / 2) begin
            repeat (260) send_request(OP_TICK, '0);
            storm_done = 1'b1;
         end
      end
   endtask

   // Main sequence.
   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_type    = OP_SUBMIT;
      req_seqno   = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      reset_connection();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows from reset, with default registers.
      foreach (opening_rows[i]) begin
         send_request(opening_rows[i].op, opening_rows[i].sn);
         if (opening_rows[i].typed) due_reports[due_reports.size() - 1] = opening_rows[i].want;
      end
      wait_drained();

      // Smallest settings, sender idles rarely, receiver stalls often.
      write_settings(1, 1, 1);
      random_phase(120, 1'b1);
      wait_drained();

      // Largest settings, idle pattern reversed.
      send_idle_pct  = 66;
      recv_stall_pct = 13;
      write_settings(16, 255, 255);
      random_phase(120, 1'b1);
      wait_drained();

      // Middle settings, no idling at all.
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      write_settings($urandom_range(2, 15), $urandom_range(2, 10), $urandom_range(2, 20));
      random_phase(120, 1'b0);
      wait_drained();

      // Shrink the window to one, then close the connection.
      write_settings(16, 1, 3);
      csr_write(REG_WINDOW, CSR_DATA_BITS'(1));
      foreach (closing_rows[i]) begin
         send_request(closing_rows[i].op, closing_rows[i].sn);
      end
      wait_drained();

      if (due_reports.size() != 0) bad_fields++;
      if (bad_fields == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
